FILE: hw/rtl/lztd_pkg.sv
// Shared types and constants for the LZ77 token decompressor.
// Request and result payload structs, status codes, controller/datapath links.
// No dependencies.
`default_nettype none
package lztd_pkg;

  localparam int unsigned CountW = 24;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_OVERFLOW = 3'd1;
  localparam logic [2:0] ST_BADREF   = 3'd2;
  localparam logic [2:0] ST_TRUNC    = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;

  typedef struct packed {
    logic       func;
    logic [7:0] in_byte;
    logic       in_last;
  } in_req_t;

  typedef struct packed {
    logic [7:0]        out_byte;
    logic              has_data;
    logic              burst_end;
    logic [2:0]        status;
    logic              block_done;
    logic [CountW-1:0] total_length;
  } out_res_t;

  typedef struct packed {
    logic byte_go;
    logic pull_go;
    logic rd;
    logic wr;
  } cmd_t;

  typedef struct packed {
    logic copy_pending;
    logic burst_last;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lz77_token_decompressor.sv
// LZ77 token decompressor top level: controller, datapath and checks.
// Byte requests: the result is registered, shown the cycle after acceptance.
// Pull requests: each copied byte is a history read, then a write-back that
// waits for a free result register; a burst holds at most PULL_BURST bytes.
// Reset clears parser state and sets max_output to all ones; history is not
// cleared, and no clearing pass runs.
`default_nettype none
module lz77_token_decompressor #(
  parameter int unsigned HISTORY_DEPTH = 131072,
  parameter int unsigned PULL_BURST    = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [23:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire lztd_pkg::in_req_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lztd_pkg::out_res_t      out_data_o
);
  import lztd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  lztd_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_func_i (in_data_i.func),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lztd_dpath #(
    .HISTORY_DEPTH(HISTORY_DEPTH),
    .PULL_BURST   (PULL_BURST)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  a_done_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.block_done |-> out_data_o.burst_end)
    else $error("block_done without burst_end");

  a_mid_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.burst_end |-> out_data_o.has_data &&
    out_data_o.status == ST_OK)
    else $error("non-final result is not ok data");

  a_total_on_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.total_length != 24'd0 |-> out_data_o.block_done &&
    out_data_o.status == ST_OK)
    else $error("total_length outside successful completion");

  a_no_accept_mid_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.rd |-> !in_ready_o)
    else $error("request accepted during copy");

endmodule
`default_nettype wire

FILE: hw/rtl/lztd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lztd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 131072
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/lztd_ctrl.sv
// Controller: request acceptance and the two-step copy sequence.
// Depends on lztd_pkg.
`default_nettype none
module lztd_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            in_func_i,
  output logic                 in_ready_o,
  input  wire lztd_pkg::stat_t stat_i,
  output lztd_pkg::cmd_t       cmd_o
);
  import lztd_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_WR   = 2'd2;

  logic [1:0] state_q, state_d;
  logic       take;

  assign in_ready_o    = (state_q == S_IDLE) && stat_i.out_free;
  assign take          = in_valid_i && in_ready_o;
  assign cmd_o.byte_go = take && !in_func_i;
  assign cmd_o.pull_go = take && in_func_i && stat_i.copy_pending;
  assign cmd_o.rd      = (state_q == S_RD);
  assign cmd_o.wr      = (state_q == S_WR) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (cmd_o.pull_go) begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_WR;
      end
      S_WR: begin
        if (stat_i.out_free) begin
          state_d = stat_i.burst_last ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lztd_dpath.sv
// Datapath: token parser registers, history store, copy counters, result register.
// Depends on lztd_pkg and lztd_ram.
`default_nettype none
module lztd_dpath #(
  parameter int unsigned HISTORY_DEPTH = 131072,
  parameter int unsigned PULL_BURST    = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_valid_i,
  input  wire logic [23:0]       cfg_data_i,
  input  wire lztd_pkg::in_req_t in_data_i,
  input  wire lztd_pkg::cmd_t    cmd_i,
  output lztd_pkg::stat_t        stat_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output lztd_pkg::out_res_t     out_data_o
);
  import lztd_pkg::*;

  localparam int unsigned AW  = $clog2(HISTORY_DEPTH);
  localparam int unsigned BCW = $clog2(PULL_BURST + 1);

  localparam logic [2:0] PH_FIRST = 3'd0;
  localparam logic [2:0] PH_CTRL  = 3'd1;
  localparam logic [2:0] PH_LIT   = 3'd2;
  localparam logic [2:0] PH_EXT   = 3'd3;
  localparam logic [2:0] PH_NEAR  = 3'd4;
  localparam logic [2:0] PH_FARHI = 3'd5;
  localparam logic [2:0] PH_FARLO = 3'd6;
  localparam logic [2:0] PH_DRAIN = 3'd7;

  logic [23:0]  max_q;
  logic [2:0]   phase_q, phase_d;
  logic [5:0]   lit_q, lit_d;
  logic [23:0]  mlen_q, mlen_d;
  logic [15:0]  ohigh_q, ohigh_d;
  logic [23:0]  crem_q, crem_d;
  logic [16:0]  cdist_q, cdist_d;
  logic [23:0]  oc_q, oc_d;
  logic [AW-1:0] wptr_q, wptr_d;
  logic [BCW-1:0] bcnt_q, bcnt_d;
  logic         out_valid_q;
  out_res_t     out_q, out_d;
  logic         out_load;

  logic          ram_we;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] ram_raddr;
  logic [AW:0]   wrap_sum;
  logic [AW-1:0] wptr_inc;

  logic [7:0]  b;
  logic [7:0]  c;
  logic [24:0] lit_need;
  logic [24:0] ext_sum;
  logic [25:0] need;
  logic [16:0] match_dist;
  logic        fin;
  logic        fail;
  logic [2:0]  fail_st;
  logic        restart;
  logic        burst_last;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign stat_o.out_free     = !out_valid_q || out_ready_i;
  assign stat_o.copy_pending = (crem_q != '0);
  assign burst_last = (crem_q == 24'd1) || (bcnt_q == BCW'(PULL_BURST - 1));
  assign stat_o.burst_last = burst_last;

  assign wptr_inc = (wptr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
  assign wrap_sum = {1'b0, wptr_q} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(cdist_q);
  assign ram_raddr = (wptr_q >= AW'(cdist_q)) ? wptr_q - AW'(cdist_q) : wrap_sum[AW-1:0];

  assign b        = in_data_i.in_byte;
  assign c        = (phase_q == PH_FIRST) ? {3'b000, b[4:0]} : b;
  assign lit_need = {1'b0, oc_q} + 25'(c) + 25'd1;
  assign ext_sum  = {1'b0, mlen_q} + 25'(b);
  assign need     = {2'b00, oc_q} + {2'b00, mlen_q} + 26'd3;
  assign match_dist = (phase_q == PH_FARLO) ? 17'(ohigh_q) + 17'(b) + 17'd8192
                                            : 17'(ohigh_q) + 17'(b) + 17'd1;

  lztd_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wptr_q),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    phase_d  = phase_q;
    lit_d    = lit_q;
    mlen_d   = mlen_q;
    ohigh_d  = ohigh_q;
    crem_d   = crem_q;
    cdist_d  = cdist_q;
    oc_d     = oc_q;
    wptr_d   = wptr_q;
    bcnt_d   = bcnt_q;
    out_load = 1'b0;
    out_d    = '0;
    ram_we   = 1'b0;
    ram_wdata = b;
    fail     = 1'b0;
    fail_st  = ST_OK;
    fin      = 1'b0;
    restart  = 1'b0;

    if (cmd_i.byte_go) begin
      if (crem_q != '0) begin
        fail    = 1'b1;
        fail_st = ST_BUSY;
      end else begin
        case (phase_q)
          PH_FIRST, PH_CTRL: begin
            if (c < 8'd32) begin
              if (lit_need > {1'b0, max_q}) begin
                fail    = 1'b1;
                fail_st = ST_OVERFLOW;
              end else if (in_data_i.in_last) begin
                fail    = 1'b1;
                fail_st = ST_TRUNC;
              end else begin
                lit_d   = 6'(c) + 6'd1;
                phase_d = PH_LIT;
              end
            end else if (in_data_i.in_last) begin
              fail    = 1'b1;
              fail_st = ST_TRUNC;
            end else begin
              mlen_d  = 24'(c[7:5]) - 24'd1;
              ohigh_d = {3'b000, c[4:0], 8'h00};
              phase_d = (c[7:5] == 3'd7) ? PH_EXT : PH_NEAR;
            end
          end
          PH_LIT: begin
            if (in_data_i.in_last && lit_q > 6'd1) begin
              fail    = 1'b1;
              fail_st = ST_TRUNC;
            end else begin
              ram_we   = 1'b1;
              oc_d     = oc_q + 24'd1;
              wptr_d   = wptr_inc;
              out_load = 1'b1;
              out_d.out_byte  = b;
              out_d.has_data  = 1'b1;
              out_d.burst_end = 1'b1;
              if (lit_q > 6'd0) begin
                lit_d = lit_q - 6'd1;
              end
              if (lit_q <= 6'd1) begin
                if (in_data_i.in_last) begin
                  out_d.block_done   = 1'b1;
                  out_d.total_length = oc_q + 24'd1;
                  restart            = 1'b1;
                end else begin
                  phase_d = PH_CTRL;
                end
              end
            end
          end
          PH_EXT: begin
            if (in_data_i.in_last) begin
              fail    = 1'b1;
              fail_st = ST_TRUNC;
            end else begin
              mlen_d = ext_sum[24] ? 24'hFFFFFF : ext_sum[23:0];
              if (b != 8'hFF) begin
                phase_d = PH_NEAR;
              end
            end
          end
          PH_NEAR: begin
            if (b == 8'hFF && ohigh_q == 16'h1F00) begin
              if (in_data_i.in_last) begin
                fail    = 1'b1;
                fail_st = ST_TRUNC;
              end else begin
                phase_d = PH_FARHI;
              end
            end else begin
              fin = 1'b1;
            end
          end
          PH_FARHI: begin
            if (in_data_i.in_last) begin
              fail    = 1'b1;
              fail_st = ST_TRUNC;
            end else begin
              ohigh_d = {b, 8'h00};
              phase_d = PH_FARLO;
            end
          end
          PH_FARLO: begin
            fin = 1'b1;
          end
          default: begin
            restart = 1'b1;
          end
        endcase
        if (fin) begin
          if (need > {2'b00, max_q}) begin
            fail    = 1'b1;
            fail_st = ST_OVERFLOW;
          end else if (24'(match_dist) > oc_q) begin
            fail    = 1'b1;
            fail_st = ST_BADREF;
          end else begin
            crem_d  = mlen_q + 24'd3;
            cdist_d = match_dist;
            phase_d = in_data_i.in_last ? PH_DRAIN : PH_CTRL;
          end
        end
      end
      if (fail) begin
        restart  = 1'b1;
        out_load = 1'b1;
        out_d.burst_end  = 1'b1;
        out_d.status     = fail_st;
        out_d.block_done = 1'b1;
      end
    end

    if (cmd_i.pull_go) begin
      bcnt_d = '0;
    end

    if (cmd_i.wr) begin
      ram_we    = 1'b1;
      ram_wdata = ram_rdata;
      out_load  = 1'b1;
      out_d.out_byte  = ram_rdata;
      out_d.has_data  = 1'b1;
      out_d.burst_end = burst_last;
      oc_d    = oc_q + 24'd1;
      wptr_d  = wptr_inc;
      crem_d  = crem_q - 24'd1;
      bcnt_d  = bcnt_q + 1'b1;
      if (crem_q == 24'd1 && phase_q == PH_DRAIN) begin
        out_d.block_done   = 1'b1;
        out_d.total_length = oc_q + 24'd1;
        restart            = 1'b1;
      end
    end

    if (restart) begin
      phase_d = PH_FIRST;
      lit_d   = '0;
      mlen_d  = '0;
      ohigh_d = '0;
      crem_d  = '0;
      cdist_d = '0;
      oc_d    = '0;
      wptr_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q       <= 24'hFFFFFF;
      phase_q     <= PH_FIRST;
      lit_q       <= '0;
      mlen_q      <= '0;
      ohigh_q     <= '0;
      crem_q      <= '0;
      cdist_q     <= '0;
      oc_q        <= '0;
      wptr_q      <= '0;
      bcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        max_q <= cfg_data_i;
      end
      phase_q <= phase_d;
      lit_q   <= lit_d;
      mlen_q  <= mlen_d;
      ohigh_q <= ohigh_d;
      crem_q  <= crem_d;
      cdist_q <= cdist_d;
      oc_q    <= oc_d;
      wptr_q  <= wptr_d;
      bcnt_q  <= bcnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

endmodule
`default_nettype wire
